// ----- rtl/hpq_pkg.sv -----
`default_nettype none

package hpq_pkg;

	// width of the fill count field on the result channel
	localparam int unsigned FILL_W = 7;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic {
		CMD_PUSH = 1'b0,
		CMD_POP  = 1'b1
	} cmd_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_UP_RD,
		S_UP_CMP,
		S_POP_ROOT,
		S_POP_LAST,
		S_POP_X,
		S_DN_RD_L,
		S_DN_RD_R,
		S_DN_CMP,
		S_FINISH
	} state_t;

	// request from the channel side to the sift engine
	typedef struct packed {
		logic start;
		cmd_t cmd;
		logic slot_free;
	} req_t;

	// engine status back to the channel side
	typedef struct packed {
		logic    idle;
		logic    done;
		status_t status;
	} rsp_t;

endpackage

`default_nettype wire

// ----- rtl/binary_heap_priority_queue.sv -----
// binary heap priority queue of key and tag entries, held in one single-port-read
// synchronous ram. a push (command 0) stores the entry at the end and sifts it up;
// a pop (command 1) returns the best entry and sifts the last entry down from the
// root. cfg_wdata written with cfg_we selects smallest key first (0) or largest
// key first (1); write it only while no transfer is in flight. one result per
// item, carrying the popped entry (zero on a push), a status (ok, pop on empty,
// push on full dropped) and the entry count afterwards. items are handled one at
// a time. a push reads and compares one parent per level climbed; a pop reads
// the root, then the last entry, then one or both children per level descended;
// a push on full or a pop on empty goes straight to its result. at depth 64 a
// push climbs at most six levels (from the last slot) and a pop descends at
// most five, paced by the one ram read port and its registered read data. the
// engine is ready for the next item in the cycle after handing its result to
// the output register, even while that result waits there; a result that
// cannot be handed over holds the engine until the output register frees up.
`default_nettype none

module binary_heap_priority_queue #(
	parameter int unsigned DEPTH     = 64,
	parameter int unsigned KEY_WIDTH = 32,
	parameter int unsigned TAG_WIDTH = 16
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// configuration
	input  wire logic                        cfg_we,
	input  wire logic                        cfg_wdata,
	// input channel
	input  wire logic                        item_valid,
	output logic                             item_ready,
	input  wire logic                        command,
	input  wire logic [KEY_WIDTH-1:0]        item_key,
	input  wire logic [TAG_WIDTH-1:0]        item_tag,
	// result channel
	output logic                             result_valid,
	input  wire logic                        result_ready,
	output logic      [KEY_WIDTH-1:0]        out_key,
	output logic      [TAG_WIDTH-1:0]        out_tag,
	output logic      [1:0]                  status,
	output logic      [hpq_pkg::FILL_W-1:0]  fill_count
);

	import hpq_pkg::*;

	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic                 order_mode_q;
	logic                 result_valid_q;
	logic [KEY_WIDTH-1:0] out_key_q;
	logic [TAG_WIDTH-1:0] out_tag_q;
	status_t              status_q;
	logic [FILL_W-1:0]    fill_q;

	req_t                 req;
	rsp_t                 rsp;
	logic [KEY_WIDTH-1:0] res_key;
	logic [TAG_WIDTH-1:0] res_tag;
	logic [CW-1:0]        count;

	// order select register, bit 0 only
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_mode_q <= 1'b0;
		end else if (cfg_we) begin
			order_mode_q <= cfg_wdata;
		end
	end

	// engine takes a new item whenever it is idle
	assign item_ready    = rsp.idle;
	assign req.start     = item_valid && item_ready;
	assign req.cmd       = cmd_t'(command);
	// output slot is free when empty or being drained this cycle
	assign req.slot_free = !result_valid_q || result_ready;

	hpq_engine #(
		.DEPTH    (DEPTH),
		.KEY_WIDTH(KEY_WIDTH),
		.TAG_WIDTH(TAG_WIDTH)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.item_key  (item_key),
		.item_tag  (item_tag),
		.order_mode(order_mode_q),
		.rsp       (rsp),
		.res_key   (res_key),
		.res_tag   (res_tag),
		.count     (count)
	);

	// output register: holds a finished result until its transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (rsp.done) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp.done) begin
			out_key_q <= res_key;
			out_tag_q <= res_tag;
			status_q  <= rsp.status;
			// count wraps into the field width for large depths
			fill_q    <= FILL_W'(count);
		end
	end

	assign result_valid = result_valid_q;
	assign out_key      = out_key_q;
	assign out_tag      = out_tag_q;
	assign status       = status_q;
	assign fill_count   = fill_q;

endmodule

`default_nettype wire

// ----- rtl/hpq_ram.sv -----
`default_nettype none

module hpq_ram #(
	parameter int unsigned WIDTH = 48,
	parameter int unsigned DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ----- rtl/hpq_engine.sv -----
`default_nettype none

module hpq_engine #(
	parameter int unsigned DEPTH     = 64,
	parameter int unsigned KEY_WIDTH = 32,
	parameter int unsigned TAG_WIDTH = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire hpq_pkg::req_t          req,
	input  wire logic [KEY_WIDTH-1:0]   item_key,
	input  wire logic [TAG_WIDTH-1:0]   item_tag,
	input  wire logic                   order_mode,
	output hpq_pkg::rsp_t               rsp,
	output logic      [KEY_WIDTH-1:0]   res_key,
	output logic      [TAG_WIDTH-1:0]   res_tag,
	output logic [$clog2(DEPTH+1)-1:0]  count
);

	import hpq_pkg::*;

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned LW = AW + 2;
	localparam int unsigned EW = KEY_WIDTH + TAG_WIDTH;

	function automatic logic beats(input logic [KEY_WIDTH-1:0] a,
		input logic [KEY_WIDTH-1:0] b, input logic mode);
		return mode ? (a > b) : (a < b);
	endfunction

	state_t               state_q, state_d;
	logic [CW-1:0]        cnt_q, cnt_d;
	logic [AW-1:0]        pos_q, pos_d;
	logic [EW-1:0]        x_q, x_d;
	logic [EW-1:0]        l_q, l_d;
	logic [KEY_WIDTH-1:0] rkey_q, rkey_d;
	logic [TAG_WIDTH-1:0] rtag_q, rtag_d;
	status_t              stat_q, stat_d;

	logic                 mem_we;
	logic [AW-1:0]        mem_waddr;
	logic [EW-1:0]        mem_wdata;
	logic [AW-1:0]        mem_raddr;
	logic [EW-1:0]        mem_rdata;

	logic [LW-1:0]        lc;
	logic [LW-1:0]        rc;
	logic [AW-1:0]        parent;
	logic [KEY_WIDTH-1:0] x_key, l_key, rd_key;
	logic                 l_wins, x_beats_l, x_beats_r;

	hpq_ram #(
		.WIDTH(EW),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	assign lc        = {1'b0, pos_q, 1'b1};
	assign rc        = lc + LW'(1);
	assign parent    = (pos_q - AW'(1)) >> 1;
	assign x_key     = x_q[EW-1 -: KEY_WIDTH];
	assign l_key     = l_q[EW-1 -: KEY_WIDTH];
	assign rd_key    = mem_rdata[EW-1 -: KEY_WIDTH];
	assign l_wins    = beats(l_key, rd_key, order_mode);
	assign x_beats_l = beats(x_key, l_key, order_mode);
	assign x_beats_r = beats(x_key, rd_key, order_mode);

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		pos_d     = pos_q;
		x_d       = x_q;
		l_d       = l_q;
		rkey_d    = rkey_q;
		rtag_d    = rtag_q;
		stat_d    = stat_q;
		mem_we    = 1'b0;
		mem_waddr = pos_q;
		mem_wdata = x_q;
		mem_raddr = '0;
		case (state_q)
			S_IDLE: begin
				if (req.start) begin
					rkey_d = '0;
					rtag_d = '0;
					stat_d = ST_OK;
					if (req.cmd == CMD_PUSH) begin
						if (cnt_q == CW'(DEPTH)) begin
							stat_d  = ST_FULL;
							state_d = S_FINISH;
						end else begin
							x_d     = {item_key, item_tag};
							pos_d   = cnt_q[AW-1:0];
							cnt_d   = cnt_q + CW'(1);
							state_d = S_UP_RD;
						end
					end else begin
						if (cnt_q == '0) begin
							stat_d  = ST_EMPTY;
							state_d = S_FINISH;
						end else begin
							cnt_d   = cnt_q - CW'(1);
							state_d = S_POP_ROOT;
						end
					end
				end
			end
			S_UP_RD: begin
				if (pos_q == '0) begin
					mem_we  = 1'b1;
					state_d = S_FINISH;
				end else begin
					mem_raddr = parent;
					state_d   = S_UP_CMP;
				end
			end
			S_UP_CMP: begin
				mem_we = 1'b1;
				if (beats(x_key, rd_key, order_mode)) begin
					// parent moves down, keep climbing
					mem_wdata = mem_rdata;
					pos_d     = parent;
					state_d   = S_UP_RD;
				end else begin
					state_d = S_FINISH;
				end
			end
			S_POP_ROOT: begin
				mem_raddr = '0;
				state_d   = S_POP_LAST;
			end
			S_POP_LAST: begin
				rkey_d = rd_key;
				rtag_d = mem_rdata[TAG_WIDTH-1:0];
				if (cnt_q == '0) begin
					state_d = S_FINISH;
				end else begin
					mem_raddr = cnt_q[AW-1:0];
					state_d   = S_POP_X;
				end
			end
			S_POP_X: begin
				x_d     = mem_rdata;
				pos_d   = '0;
				state_d = S_DN_RD_L;
			end
			S_DN_RD_L: begin
				if (lc >= LW'(cnt_q)) begin
					mem_we  = 1'b1;
					state_d = S_FINISH;
				end else begin
					mem_raddr = lc[AW-1:0];
					state_d   = S_DN_RD_R;
				end
			end
			S_DN_RD_R: begin
				l_d = mem_rdata;
				if (rc < LW'(cnt_q)) begin
					mem_raddr = rc[AW-1:0];
					state_d   = S_DN_CMP;
				end else begin
					// only the left child is live
					mem_we = 1'b1;
					if (beats(rd_key, x_key, order_mode)) begin
						mem_wdata = mem_rdata;
						pos_d     = lc[AW-1:0];
						state_d   = S_DN_RD_L;
					end else begin
						state_d = S_FINISH;
					end
				end
			end
			S_DN_CMP: begin
				mem_we = 1'b1;
				if (l_wins ? x_beats_l : x_beats_r) begin
					state_d = S_FINISH;
				end else begin
					// equal keys still swap with the chosen child
					mem_wdata = l_wins ? l_q : mem_rdata;
					pos_d     = l_wins ? lc[AW-1:0] : rc[AW-1:0];
					state_d   = S_DN_RD_L;
				end
			end
			S_FINISH: begin
				if (req.slot_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			pos_q   <= '0;
			stat_q  <= ST_OK;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			pos_q   <= pos_d;
			stat_q  <= stat_d;
		end
	end

	always_ff @(posedge clk) begin
		x_q    <= x_d;
		l_q    <= l_d;
		rkey_q <= rkey_d;
		rtag_q <= rtag_d;
	end

	assign rsp.idle   = (state_q == S_IDLE);
	assign rsp.done   = (state_q == S_FINISH) && req.slot_free;
	assign rsp.status = stat_q;
	assign res_key    = rkey_q;
	assign res_tag    = rtag_q;
	assign count      = cnt_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("entry count above depth");

	a_write_live: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (CW'(mem_waddr) < cnt_q))
		else $error("heap write outside live entries");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FINISH && stat_q == ST_FULL) |-> (cnt_q == CW'(DEPTH)))
		else $error("full status with room left");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && req.start && req.cmd == CMD_PUSH
			&& cnt_q != CW'(DEPTH))
		|=> (cnt_q == $past(cnt_q) + CW'(1)))
		else $error("accepted push did not add an entry");

endmodule

`default_nettype wire

// ----- tb/sv/heap_queue_checker.sv -----
module heap_queue_checker #(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned KEY_W = 32,
	parameter int unsigned TAG_W = 16
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic                       cfg_wdata,
	input  wire logic                       item_valid,
	input  wire logic                       item_ready,
	input  wire logic                       command,
	input  wire logic [KEY_W-1:0]           item_key,
	input  wire logic [TAG_W-1:0]           item_tag,
	input  wire logic                       result_valid,
	input  wire logic                       result_ready,
	input  wire logic [KEY_W-1:0]           out_key,
	input  wire logic [TAG_W-1:0]           out_tag,
	input  wire logic [1:0]                 status,
	input  wire logic [hpq_pkg::FILL_W-1:0] fill_count,
	output int                              mismatches,
	output int                              open_items
);
	import hpq_pkg::*;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [TAG_W-1:0] tag;
	} entry_t;

	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [TAG_W-1:0]  tag;
		status_t           st;
		logic [FILL_W-1:0] fill;
	} served_t;

	entry_t      heap_slots [DEPTH];
	int unsigned held = 0;
	logic        largest_first = 1'b0;
	served_t     awaited_results [$];

	initial begin
		mismatches = 0;
		open_items = 0;
	end

	function automatic bit outranks(input entry_t a, input entry_t b);
		return largest_first ? (a.key > b.key) : (a.key < b.key);
	endfunction

	function automatic void swap_slots(input int unsigned a, input int unsigned b);
		entry_t t;
		t             = heap_slots[a];
		heap_slots[a] = heap_slots[b];
		heap_slots[b] = t;
	endfunction

	// one item in, the result it should produce out, heap state updated
	function automatic served_t apply_command(input logic cmd, input logic [KEY_W-1:0] key,
			input logic [TAG_W-1:0] tag);
		served_t     r;
		int unsigned pos, up, last, lc, pick;
		bit          moving;
		r      = '0;
		r.st   = ST_OK;
		if (cmd_t'(cmd) == CMD_PUSH) begin
			if (held >= DEPTH) begin
				r.st = ST_FULL;
			end else begin
				pos                 = held;
				heap_slots[pos].key = key;
				heap_slots[pos].tag = tag;
				held                = held + 1;
				moving              = 1'b1;
				while (moving && pos > 0) begin
					up = (pos - 1) / 2;
					if (outranks(heap_slots[pos], heap_slots[up])) begin
						swap_slots(pos, up);
						pos = up;
					end else
						moving = 1'b0;
				end
			end
		end else if (held == 0) begin
			r.st = ST_EMPTY;
		end else begin
			last          = held - 1;
			r.key         = heap_slots[0].key;
			r.tag         = heap_slots[0].tag;
			held          = last;
			heap_slots[0] = heap_slots[last];
			// the slot at 'last' still takes part in the sift, as a stale copy
			pos    = 0;
			moving = 1'b1;
			while (moving) begin
				lc = 2 * pos + 1;
				if (lc > last || lc >= DEPTH) begin
					moving = 1'b0;
				end else if (lc == last) begin
					if (!outranks(heap_slots[pos], heap_slots[lc]))
						swap_slots(lc, pos);
					moving = 1'b0;
				end else begin
					pick = outranks(heap_slots[lc], heap_slots[lc + 1]) ? lc : lc + 1;
					if (outranks(heap_slots[pos], heap_slots[pick])) begin
						moving = 1'b0;
					end else begin
						swap_slots(pick, pos);
						pos = pick;
					end
				end
			end
		end
		r.fill = FILL_W'(held);
		return r;
	endfunction

	function automatic void note_mismatch(input string what);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: mismatch: %s", $time, what);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		served_t want;
		if (!arst_n) begin
			held          = 0;
			largest_first = 1'b0;
			awaited_results.delete();
		end else begin
			if (result_valid && result_ready) begin
				if (awaited_results.size() == 0) begin
					note_mismatch($sformatf(
						"result transfer with nothing awaited key=%h tag=%h status=%0d fill=%0d",
						out_key, out_tag, status, fill_count));
				end else begin
					want = awaited_results.pop_front();
					if (out_key !== want.key)
						note_mismatch($sformatf("out_key expected %h got %h", want.key, out_key));
					if (out_tag !== want.tag)
						note_mismatch($sformatf("out_tag expected %h got %h", want.tag, out_tag));
					if (status !== want.st)
						note_mismatch($sformatf("status expected %0d got %0d", want.st, status));
					if (fill_count !== want.fill)
						note_mismatch($sformatf("fill_count expected %0d got %0d", want.fill,
							fill_count));
				end
			end
			if (item_valid && item_ready)
				awaited_results.push_back(apply_command(command, item_key, item_tag));
			if (cfg_we)
				largest_first = cfg_wdata;
		end
		open_items = awaited_results.size();
	end

endmodule

// ----- tb/sv/testbench.sv -----
module testbench;
	import hpq_pkg::*;

	// receiver hold-off used to back the queue up into its input
	localparam int HOLD_CYCLES = 250;
	// cycles without any transfer before the run is declared hung
	localparam int STALL_LIMIT = 3000;
	// random items per order phase
	localparam int PHASE_ITEMS = 300;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic                cfg_wdata;
	logic                item_valid;
	logic                item_ready;
	logic                command;
	logic [31:0]         item_key;
	logic [15:0]         item_tag;
	logic                result_valid;
	logic                result_ready;
	logic [31:0]         out_key;
	logic [15:0]         out_tag;
	logic [1:0]          status;
	logic [FILL_W-1:0]   fill_count;

	int mismatches;
	int open_items;

	// shared between the sender and the receiver processes
	bit long_hold = 1'b0;   // raised by the sender, cleared by the receiver
	bit quiet     = 1'b0;   // closing stretch: no idling on either side
	int gap_pct   = 0;      // sender idling density for the current stretch
	int sent      = 0;      // input transfers so far

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	binary_heap_priority_queue dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.command      (command),
		.item_key     (item_key),
		.item_tag     (item_tag),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.out_key      (out_key),
		.out_tag      (out_tag),
		.status       (status),
		.fill_count   (fill_count)
	);

	heap_queue_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.command      (command),
		.item_key     (item_key),
		.item_tag     (item_tag),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.out_key      (out_key),
		.out_tag      (out_tag),
		.status       (status),
		.fill_count   (fill_count),
		.mismatches   (mismatches),
		.open_items   (open_items)
	);

	// keys lean towards a narrow range so that equal keys and ties between
	// children turn up often, with the extremes mixed in
	function automatic logic [31:0] rand_key();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return $urandom_range(0, 15);
			4:          return 32'h0000_0000;
			5:          return 32'hFFFF_FFFF;
			6:          return 32'hFFFF_FFF0 | $urandom_range(0, 15);
			default:    return $urandom;
		endcase
	endfunction

	// one input transfer; called and left at a falling edge, valid stays high
	// on return so that back-to-back items never drop it
	task automatic offer(input cmd_t cmd, input logic [31:0] key, input logic [15:0] tag);
		if (!quiet && gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
		item_valid <= 1'b1;
		command    <= cmd;
		item_key   <= key;
		item_tag   <= tag;
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
		sent++;
		@(negedge clk);
	endtask

	// sender pause until every awaited result has come back
	task automatic drain();
		item_valid <= 1'b0;
		while (open_items != 0)
			@(negedge clk);
	endtask

	// order register is only touched with nothing in flight
	task automatic write_order(input logic largest);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= largest;
		@(negedge clk);
		cfg_we    <= 1'b0;
		@(negedge clk);
	endtask

	// well-formed deep sequence: fill past full, then empty past empty
	task automatic fill_then_empty();
		gap_pct = $urandom_range(0, 1) ? 0 : 10;
		repeat (66)
			offer(CMD_PUSH, rand_key(), 16'($urandom));
		repeat (67)
			offer(CMD_POP, $urandom, 16'($urandom));
	endtask

	// stretch of mixed traffic with a random push/pop balance
	task automatic mixed_stretch();
		int len, push_pct;
		len = $urandom_range(10, 60);
		case ($urandom_range(0, 2))
			0:       push_pct = 85;
			1:       push_pct = 50;
			default: push_pct = 15;
		endcase
		case ($urandom_range(0, 2))
			0:       gap_pct = 0;
			1:       gap_pct = 4;
			default: gap_pct = 15;
		endcase
		repeat (len) begin
			if ($urandom_range(1, 100) <= push_pct)
				offer(CMD_PUSH, rand_key(), 16'($urandom));
			else
				offer(CMD_POP, $urandom, 16'($urandom));
		end
	endtask

	initial begin : stimulus
		int phase, phase_start;
		arst_n     = 1'b0;
		cfg_we     = 1'b0;
		cfg_wdata  = 1'b0;
		item_valid = 1'b0;
		command    = 1'b0;
		item_key   = '0;
		item_tag   = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// smallest first: empty pop, key extremes, equal keys, drain to empty
		write_order(1'b0);
		gap_pct = 4;
		offer(CMD_POP,  32'h0000_0000, 16'h0000);
		offer(CMD_PUSH, 32'h0000_0005, 16'h0001);
		offer(CMD_PUSH, 32'h0000_0000, 16'hFFFF);
		offer(CMD_PUSH, 32'hFFFF_FFFF, 16'h0000);
		offer(CMD_PUSH, 32'h0000_0005, 16'h0002);
		offer(CMD_PUSH, 32'h0000_0005, 16'h0003);
		offer(CMD_PUSH, 32'h0000_0005, 16'h0004);
		offer(CMD_PUSH, 32'h0000_0003, 16'h00A5);
		repeat (8)
			offer(CMD_POP, 32'hFFFF_FFFF, 16'hFFFF);

		// largest first: extremes and a tie
		write_order(1'b1);
		offer(CMD_PUSH, 32'h0000_0000, 16'hAAAA);
		offer(CMD_PUSH, 32'hFFFF_FFFF, 16'h5555);
		offer(CMD_PUSH, 32'h0000_0007, 16'h0001);
		offer(CMD_PUSH, 32'h0000_0007, 16'h0002);
		repeat (4)
			offer(CMD_POP, 32'h0000_0000, 16'h0000);

		// random phases alternating the order; the heap is not emptied across
		// an order change, so leftover entries see the other ordering too
		for (phase = 0; phase < 6; phase++) begin
			if (phase == 5)
				quiet = 1'b1;
			write_order(phase[0]);
			phase_start = sent;
			// receiver stalls for a long while as the sender keeps pushing
			if (phase == 2)
				long_hold = 1'b1;
			fill_then_empty();
			while (sent - phase_start < PHASE_ITEMS)
				mixed_stretch();
		end

		drain();
		repeat (40) @(negedge clk);
		if (mismatches == 0 && open_items == 0)
			$display("PASS binary_heap_priority_queue");
		else
			$display("FAIL binary_heap_priority_queue");
		$finish;
	end

	// result side: bursts of back-pressure with changing density, the
	// requested long hold-off, and none in the closing stretch
	initial begin : result_sink
		int sink_pct, span;
		sink_pct     = 0;
		span         = 0;
		result_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (span == 0) begin
				span = $urandom_range(50, 300);
				case ($urandom_range(0, 2))
					0:       sink_pct = 0;
					1:       sink_pct = 8;
					default: sink_pct = 30;
				endcase
			end
			span--;
			if (long_hold) begin
				result_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				long_hold = 1'b0;
				result_ready <= 1'b1;
			end else if (!quiet && sink_pct != 0 && $urandom_range(1, 100) <= sink_pct) begin
				result_ready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(negedge clk);
				result_ready <= 1'b1;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	// hang detection: any transfer on either channel restarts the count
	initial begin : watchdog
		int still;
		still = 0;
		while (still < STALL_LIMIT) begin
			@(posedge clk);
			if ((item_valid && item_ready) || (result_valid && result_ready))
				still = 0;
			else
				still++;
		end
		$display("FAIL binary_heap_priority_queue");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/hpq_pkg.sv
rtl/hpq_ram.sv
rtl/hpq_engine.sv
rtl/binary_heap_priority_queue.sv
tb/sv/heap_queue_checker.sv
tb/sv/testbench.sv
